// ===== rtl/chsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Checked heading sentence parser package
// Shared widths, character codes and fixed-point constants for the parser.
// ----------------------------------------------------------------------------
package chsp_pkg;

    // Field size limit and number of kept fraction digits.
    localparam int FIELD_LIMIT     = 13;
    localparam int FRACTION_DIGITS = 2;

    // Payload widths.
    localparam int BYTE_W    = 8;
    localparam int HEADING_W = 16;
    localparam int DEGREES_W = 9;
    localparam int ANGLE_W   = 24;
    localparam int MAG_W     = 23;

    // State widths.
    localparam int COUNT_W = $clog2(FIELD_LIMIT + 1);
    localparam int FRAC_W  = (FRACTION_DIGITS > 0) ? $clog2(FRACTION_DIGITS + 1) : 1;

    // Checksum start value after reset.
    localparam logic [BYTE_W-1:0] SEED_RESET = 8'h2B;

    // Saturation bound of the parsed magnitude.
    localparam logic [MAG_W-1:0] MAG_MAX = 23'h7F_FFFF;

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_VT      = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FF      = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_W = 8'h77;

    // Fixed-point scale and full-circle heading.
    localparam int SCALE        = 10 ** FRACTION_DIGITS;
    localparam int HEADING_FULL = 360 * SCALE;
    localparam int HEAD_CALC_W  = $clog2(HEADING_FULL + 1);

    // Reciprocal for heading / SCALE: exact for every heading up to the full circle.
    localparam longint FULL_BY_SCALE = longint'(HEADING_FULL) * longint'(SCALE);
    localparam int     DIV_SHIFT     = $clog2(FULL_BY_SCALE);
    localparam longint DIV_MULT      = ((longint'(1) << DIV_SHIFT) + longint'(SCALE) - 1)
                                       / longint'(SCALE);
    localparam int     DIV_MULT_W    = $clog2(DIV_MULT + 1);

    // Number parser flags.
    typedef struct packed {
        logic              sign;
        logic              point;
        logic              stop;
        logic              start;
        logic [FRAC_W-1:0] frac;
    } parse_flags_t;

endpackage

// ===== rtl/chsp_in_if.sv =====
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel that carries one received serial character per transfer.
// ----------------------------------------------------------------------------
interface chsp_in_if;
    import chsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== rtl/chsp_out_if.sv =====
// ----------------------------------------------------------------------------
// Heading result channel
// Valid/ready channel that carries one heading result per transfer.
// ----------------------------------------------------------------------------
interface chsp_out_if;
    import chsp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [HEADING_W-1:0] heading;
    logic [DEGREES_W-1:0] heading_degrees;
    logic                 frame_ok;
    logic                 frame_bad;

    modport source (output valid, output heading, output heading_degrees,
                    output frame_ok, output frame_bad, input ready);
    modport sink   (input valid, input heading, input heading_degrees,
                    input frame_ok, input frame_bad, output ready);

endinterface

// ===== rtl/checked_heading_sentence_parser_top.sv =====
// ----------------------------------------------------------------------------
// Checked heading sentence parser
// Finds "w," value fields in a serial byte stream, checks their XOR checksum
// and turns the leading decimal number into a clamped heading.
//
//   Channel | Role   | Payload                                        | Transfer
//   --------+--------+------------------------------------------------+------------------
//   rx      | sink   | rx_byte[7:0]                                   | valid & ready
//   res     | source | heading[15:0], heading_degrees[8:0], ok, bad   | valid & ready
//   cfg     | write  | cfg_wdata[7:0] -> checksum_seed                | cfg_wen high
//
// One byte is accepted per cycle while the result is not stalled; each byte gives one result
// through the input register, then the result register that holds the parser state.
// Sustained rate is one byte per cycle while results are taken.
// Reset is asynchronous: the parser state clears, and the running checksum and the seed return to 0x2B.
// While a result stalls, one more byte is held in the input register; then
// rx.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module checked_heading_sentence_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [chsp_pkg::BYTE_W-1:0]   cfg_wdata,
    chsp_in_if.sink                       rx,
    chsp_out_if.source                    res
);
    import chsp_pkg::*;

    // Hex digit decode: bit 4 marks a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r = {1'b1, c[3:0]};
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // Power of ten for the missing fraction digits.
    function automatic logic [13:0] pow10_of(input logic [2:0] k);
        logic [13:0] r;
        case (k)
            3'd0:    r = 14'd1;
            3'd1:    r = 14'd10;
            3'd2:    r = 14'd100;
            3'd3:    r = 14'd1000;
            3'd4:    r = 14'd10000;
            default: r = 14'd1;
        endcase
        return r;
    endfunction

    // Handshake and pipeline control.
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              out_valid_reg;
    logic              advance;

    // Parser state.
    logic [BYTE_W-1:0]            seed_reg;
    logic                         prefix_reg, prefix_next;
    logic                         in_field_reg, in_field_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic [BYTE_W-1:0]            xor_reg, xor_next;
    logic [2:0][BYTE_W-1:0]       recent_reg, recent_next;
    logic [MAG_W-1:0]             value_reg, value_next;
    parse_flags_t                 flags_reg, flags_next;
    logic [ANGLE_W-1:0]           angle_reg, angle_next;
    logic                         ok_reg, ok_next;
    logic                         bad_reg, bad_next;

    // Per-byte parser results.
    logic [MAG_W-1:0]     byte_value;
    parse_flags_t         byte_flags;
    logic [MAG_W+3:0]     mul10;
    logic [MAG_W-1:0]     mul10_sat;
    logic                 is_digit;

    // Frame check and number result.
    logic [4:0]           hex_hi, hex_lo;
    logic [BYTE_W-1:0]    calc_xor;
    logic                 frame_pass;
    logic [2:0]           missing_digits;
    logic [MAG_W+13:0]    scaled;
    logic [MAG_W-1:0]     scaled_sat;
    logic [ANGLE_W-1:0]   parse_angle;
    logic                 closed;
    logic                 prefix_mid;

    // Heading output.
    logic [ANGLE_W-1:0]                 head_diff;
    logic [HEAD_CALC_W-1:0]             head_val;
    logic [HEAD_CALC_W+DIV_MULT_W-1:0]  deg_prod;

    // An item moves from the input register into the result register.
    assign advance  = s1_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !s1_valid_reg || !out_valid_reg || res.ready;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input byte payload.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
    end

    // Checksum seed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_wen)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    // Decimal accumulate with saturation: v * 10 + digit.
    always_comb
    begin
        is_digit  = (s1_byte_reg >= CHAR_ZERO) && (s1_byte_reg <= CHAR_NINE);
        mul10     = ({4'd0, value_reg} << 3) + ({4'd0, value_reg} << 1)
                    + {{(MAG_W){1'b0}}, s1_byte_reg[3:0]};
        mul10_sat = (mul10 > {4'd0, MAG_MAX}) ? MAG_MAX : mul10[MAG_W-1:0];
    end

    // Number parser step for one field byte.
    always_comb
    begin
        byte_value = value_reg;
        byte_flags = flags_reg;
        if (flags_reg.stop)
        begin
            byte_flags = flags_reg;
        end
        else if (!flags_reg.start && (s1_byte_reg inside {CHAR_SPACE, CHAR_TAB, CHAR_LF,
                                                          CHAR_VT, CHAR_FF}))
        begin
            byte_flags = flags_reg;
        end
        else if (!flags_reg.start && (s1_byte_reg inside {CHAR_PLUS, CHAR_MINUS}))
        begin
            byte_flags.start = 1'b1;
            byte_flags.sign  = (s1_byte_reg == CHAR_MINUS);
        end
        else if (is_digit)
        begin
            byte_flags.start = 1'b1;
            if (!flags_reg.point)
            begin
                byte_value = mul10_sat;
            end
            else if (flags_reg.frac < FRAC_W'(FRACTION_DIGITS))
            begin
                byte_value      = mul10_sat;
                byte_flags.frac = flags_reg.frac + FRAC_W'(1);
            end
        end
        else if (s1_byte_reg == CHAR_DOT && !flags_reg.point)
        begin
            byte_flags.start = 1'b1;
            byte_flags.point = 1'b1;
        end
        else
        begin
            byte_flags.stop = 1'b1;
        end
    end

    // Checksum check at carriage return and the scaled, signed number.
    always_comb
    begin
        hex_hi     = hex_decode(recent_reg[1]);
        hex_lo     = hex_decode(recent_reg[0]);
        calc_xor   = xor_reg ^ recent_reg[0] ^ recent_reg[1] ^ recent_reg[2];
        frame_pass = (count_reg >= COUNT_W'(3)) && (recent_reg[2] == CHAR_STAR)
                     && hex_hi[4] && hex_lo[4] && ({hex_hi[3:0], hex_lo[3:0]} == calc_xor);

        missing_digits = 3'(FRACTION_DIGITS) - 3'(flags_reg.frac);
        scaled         = {14'd0, value_reg} * {{(MAG_W){1'b0}}, pow10_of(missing_digits)};
        scaled_sat     = (scaled > {14'd0, MAG_MAX}) ? MAG_MAX : scaled[MAG_W-1:0];
        parse_angle    = flags_reg.sign ? (ANGLE_W'(0) - {1'b0, scaled_sat})
                                        : {1'b0, scaled_sat};
    end

    // Next parser state for the byte in the input register.
    always_comb
    begin
        prefix_next   = prefix_reg;
        in_field_next = in_field_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        recent_next   = recent_reg;
        value_next    = value_reg;
        flags_next    = flags_reg;
        angle_next    = angle_reg;
        ok_next       = 1'b0;
        bad_next      = 1'b0;
        closed        = 1'b0;

        // Field bytes and field end.
        if (in_field_reg)
        begin
            if (s1_byte_reg != CHAR_CR)
            begin
                recent_next[2] = recent_reg[1];
                recent_next[1] = recent_reg[0];
                recent_next[0] = s1_byte_reg;
                xor_next       = xor_reg ^ s1_byte_reg;
                value_next     = byte_value;
                flags_next     = byte_flags;
                count_next     = count_reg + COUNT_W'(1);
                if (count_reg == COUNT_W'(FIELD_LIMIT))
                begin
                    closed   = 1'b1;
                    bad_next = 1'b1;
                end
            end
            else
            begin
                if (frame_pass)
                begin
                    angle_next = parse_angle;
                    ok_next    = 1'b1;
                end
                else
                begin
                    bad_next = 1'b1;
                end
                closed = 1'b1;
            end
        end

        if (closed)
        begin
            in_field_next = 1'b0;
            count_next    = '0;
            value_next    = '0;
            flags_next    = '0;
        end
        prefix_mid = closed ? 1'b0 : prefix_reg;

        // Field opener "w," outside a field.
        if (s1_byte_reg == CHAR_COMMA && prefix_mid)
        begin
            prefix_next = prefix_mid;
            if (!in_field_next)
            begin
                in_field_next = 1'b1;
                count_next    = '0;
                xor_next      = seed_reg;
                value_next    = '0;
                flags_next    = '0;
            end
        end
        else
        begin
            prefix_next = 1'b0;
        end
        if (s1_byte_reg == CHAR_LOWER_W)
        begin
            prefix_next = 1'b1;
        end
    end

    // Parser state and result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prefix_reg    <= 1'b0;
            in_field_reg  <= 1'b0;
            count_reg     <= '0;
            xor_reg       <= SEED_RESET;
            value_reg     <= '0;
            flags_reg     <= '0;
            angle_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            prefix_reg    <= prefix_next;
            in_field_reg  <= in_field_next;
            count_reg     <= count_next;
            xor_reg       <= xor_next;
            value_reg     <= value_next;
            flags_reg     <= flags_next;
            angle_reg     <= angle_next;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Field byte history and result flags.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            recent_reg <= recent_next;
            ok_reg     <= ok_next;
            bad_reg    <= bad_next;
        end
    end

    // Heading from the stored angle, clamped to the full circle.
    always_comb
    begin
        head_diff = ANGLE_W'(HEADING_FULL) - angle_reg;
        if (angle_reg[ANGLE_W-1])
        begin
            head_val = HEAD_CALC_W'(HEADING_FULL);
        end
        else if (angle_reg > ANGLE_W'(HEADING_FULL))
        begin
            head_val = '0;
        end
        else
        begin
            head_val = head_diff[HEAD_CALC_W-1:0];
        end
        deg_prod = {{(DIV_MULT_W){1'b0}}, head_val}
                   * {{(HEAD_CALC_W){1'b0}}, DIV_MULT_W'(DIV_MULT)};
    end

    // Result channel.
    assign res.valid           = out_valid_reg;
    assign res.heading         = HEADING_W'(head_val);
    assign res.heading_degrees = DEGREES_W'(deg_prod >> DIV_SHIFT);
    assign res.frame_ok        = ok_reg;
    assign res.frame_bad       = bad_reg;

endmodule

// ===== rtl/chsp_checker.sv =====
// ----------------------------------------------------------------------------
// Checked heading sentence parser checker
// Port-level assertions on the result stream and the input back-pressure.
// ----------------------------------------------------------------------------
module chsp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rx_valid,
    input logic                            rx_ready,
    input logic [chsp_pkg::BYTE_W-1:0]     rx_byte,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [chsp_pkg::HEADING_W-1:0]  heading,
    input logic [chsp_pkg::DEGREES_W-1:0]  heading_degrees,
    input logic                            frame_ok,
    input logic                            frame_bad
);
    import chsp_pkg::*;

    // Heading of the last transferred result; the angle is zero after reset.
    logic [HEADING_W-1:0] last_heading_reg;
    logic [31:0]          deg_low;
    logic [31:0]          deg_high;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_heading_reg <= HEADING_W'(HEADING_FULL);
        end
        else if (res_valid && res_ready)
        begin
            last_heading_reg <= heading;
        end
    end

    // Whole-degree bounds of the heading.
    assign deg_low  = 32'(heading_degrees) * 32'(SCALE);
    assign deg_high = deg_low + 32'(SCALE);

    // A result never passes and fails a field at once.
    a_ok_bad_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(frame_ok && frame_bad))
        else $error("frame_ok and frame_bad both set");

    // The heading changes only on a result that completes a good field.
    a_heading_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !frame_ok) |-> (heading == last_heading_reg))
        else $error("heading changed without a good field");

    // The heading stays within the circle and the degrees truncate it.
    a_heading_degrees: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((32'(heading) <= 32'(HEADING_FULL)) && (deg_low <= 32'(heading))
                       && (32'(heading) < deg_high)))
        else $error("heading or heading_degrees out of range");

    // With the result stalled, only one more byte is buffered.
    a_one_byte_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_valid && rx_ready && res_valid && !res_ready) |=> (!rx_ready || res_ready))
        else $error("more than one byte accepted while result stalled");

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(heading)
                                       && $stable(frame_ok) && $stable(frame_bad)))
        else $error("stalled result changed");

    // The input byte is only observed; it keeps the port list complete.
    logic unused_rx;
    assign unused_rx = ^rx_byte;

endmodule

bind checked_heading_sentence_parser_top chsp_checker u_chsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_valid        (rx.valid),
    .rx_ready        (rx.ready),
    .rx_byte         (rx.rx_byte),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .heading         (res.heading),
    .heading_degrees (res.heading_degrees),
    .frame_ok        (res.frame_ok),
    .frame_bad       (res.frame_bad)
);
